[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/pfn_pkg.sv]
// ----------------------------------------------------------------------------
// pfn_pkg
// Types, constants and helpers of the palette fade nearest color block.
// ----------------------------------------------------------------------------
`default_nettype none

package pfn_pkg;

    localparam int PALETTE_SIZE_DEF = 16;

    localparam int IDX_W    = 4;
    localparam int CH_W     = 5;
    localparam int COLOR_W  = 15;
    localparam int WORD_W   = 60;
    localparam int N_WORDS  = 4;
    localparam int FACTOR_W = 16;
    localparam int F_W      = 9;
    localparam int OP_W     = 14;
    localparam int PROD_W   = 2 * OP_W;
    localparam int TERM_W   = PROD_W - 8;
    localparam int DIST_W   = TERM_W + 2;

    localparam logic [F_W-1:0] FIX_ONE = 9'd256;

    typedef logic [1:0] ch_sel_t;
    localparam ch_sel_t CH_R = 2'd0;
    localparam ch_sel_t CH_G = 2'd1;
    localparam ch_sel_t CH_B = 2'd2;

    typedef logic [N_WORDS-1:0][WORD_W-1:0] pal_words_t;

    // Tag that travels alongside an operand pair through the shared multiplier.
    typedef struct packed {
        logic             vld;
        logic             is_dist;
        ch_sel_t          ch;
        logic [IDX_W-1:0] j;
        logic             last_j;
    } pfn_tag_t;

    function automatic logic [COLOR_W-1:0] pfn_color(input pal_words_t words,
                                                      input logic [IDX_W-1:0] idx);
        logic [WORD_W-1:0] w;
        logic [5:0]        sh;
        w  = words[idx[3:2]];
        sh = 6'(idx[1:0]) * 6'd15;
        return w[sh +: COLOR_W];
    endfunction

    function automatic logic [CH_W-1:0] pfn_chan(input logic [COLOR_W-1:0] color,
                                                  input ch_sel_t ch);
        logic [CH_W-1:0] c;
        unique case (ch)
            CH_R:    c = color[4:0];
            CH_G:    c = color[9:5];
            CH_B:    c = color[14:10];
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/palette_fade_nearest_color.sv]
// Input: a new factor is accepted only in IDLE, once the previous run has emitted its last entry;
// output stalls delay it. The single shared multiplier takes one channel term a cycle in SCALE and DIST.
// Reset: synchronous active-low aresetn clears control and the palette registers to 0.
// ----------------------------------------------------------------------------
// palette_fade_nearest_color
// Scales each palette color from entry 1 on by a clamped brightness factor and maps it to the
// nearest palette entry by sum of squared channel differences.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_fade_nearest_color
    import pfn_pkg::*;
#(
    parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic signed [FACTOR_W-1:0] s_factor,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic             [IDX_W-1:0]    m_entry_index,
    output logic             [IDX_W-1:0]    m_mapped_index,
    output logic             [COLOR_W-1:0]  m_mapped_color,
    output logic                            m_last,
    input  wire logic                       cfg_we,
    input  wire logic        [1:0]          cfg_index,
    input  wire logic        [WORD_W-1:0]   cfg_wdata
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_SIZE - 1);

    typedef enum logic [2:0] {
        IDLE,
        SCALE,
        DIST,
        DRAIN,
        EMIT
    } state_t;

    state_t state_reg;

    pal_words_t          pal_reg;
    logic [F_W-1:0]      f_reg;
    logic [IDX_W-1:0]    i_reg;
    logic [IDX_W-1:0]    j_reg;
    ch_sel_t             ch_reg;
    logic [OP_W-1:0]     sc_r_reg;
    logic [OP_W-1:0]     sc_g_reg;
    logic [OP_W-1:0]     sc_b_reg;
    logic [DIST_W-1:0]   acc_reg;
    logic [DIST_W-1:0]   best_reg;
    logic [IDX_W-1:0]    best_j_reg;

    logic                m_valid_reg;
    logic [IDX_W-1:0]    m_entry_index_reg;
    logic [IDX_W-1:0]    m_mapped_index_reg;
    logic [COLOR_W-1:0]  m_mapped_color_reg;
    logic                m_last_reg;

    logic [COLOR_W-1:0]  cur_col;
    logic [CH_W-1:0]     cur_c;
    logic [OP_W-1:0]     target;
    logic [OP_W-1:0]     sc_sel;
    logic [OP_W-1:0]     diff;
    logic [OP_W-1:0]     op_a;
    logic [OP_W-1:0]     op_b;
    pfn_tag_t            tag_in;
    pfn_tag_t            tag_out;
    logic [PROD_W-1:0]   prod;
    logic [DIST_W-1:0]   acc_sum;
    logic [OP_W-1:0]     scaled;
    logic [F_W-1:0]      f_next;
    logic                out_free;

    always_comb begin
        cur_col = pfn_color(pal_reg, (state_reg == SCALE) ? i_reg : j_reg);
        cur_c   = pfn_chan(cur_col, ch_reg);
        target  = {cur_c, 9'd0};
        unique case (ch_reg)
            CH_R:    sc_sel = sc_r_reg;
            CH_G:    sc_sel = sc_g_reg;
            CH_B:    sc_sel = sc_b_reg;
            default: sc_sel = '0;
        endcase
        diff = (target >= sc_sel) ? (target - sc_sel) : (sc_sel - target);

        if (state_reg == SCALE) begin
            op_a = OP_W'(cur_c);
            op_b = OP_W'(f_reg);
        end else begin
            op_a = diff;
            op_b = diff;
        end

        tag_in.vld     = (state_reg == SCALE) || (state_reg == DIST);
        tag_in.is_dist = (state_reg == DIST);
        tag_in.ch      = ch_reg;
        tag_in.j       = j_reg;
        tag_in.last_j  = (j_reg == LAST_IDX) && (ch_reg == CH_B);

        acc_sum = acc_reg + DIST_W'(prod[PROD_W-1:8]);
        scaled  = {prod[OP_W-2:0], 1'b0};

        if (s_factor[FACTOR_W-1]) begin
            f_next = '0;
        end else if (s_factor > $signed(FACTOR_W'(FIX_ONE))) begin
            f_next = FIX_ONE;
        end else begin
            f_next = s_factor[F_W-1:0];
        end

        out_free = !m_valid_reg || m_ready;
    end

    pfn_mul u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_a     (op_a),
        .op_b     (op_b),
        .tag_in   (tag_in),
        .prod_reg (prod),
        .tag_reg  (tag_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
            pal_reg     <= '0;
            ch_reg      <= CH_R;
            i_reg       <= '0;
            j_reg       <= '0;
            acc_reg     <= '0;
        end else begin
            if (cfg_we) begin
                pal_reg[cfg_index] <= cfg_wdata;
            end

            if (m_valid_reg && m_ready && (state_reg != EMIT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                IDLE: begin
                    if (s_valid) begin
                        f_reg     <= f_next;
                        i_reg     <= IDX_W'(1);
                        ch_reg    <= CH_R;
                        acc_reg   <= '0;
                        state_reg <= SCALE;
                    end
                end
                SCALE: begin
                    if (ch_reg == CH_B) begin
                        ch_reg    <= CH_R;
                        j_reg     <= '0;
                        state_reg <= DIST;
                    end else begin
                        ch_reg <= ch_reg + 2'd1;
                    end
                end
                DIST: begin
                    if (ch_reg == CH_B) begin
                        ch_reg <= CH_R;
                        if (j_reg == LAST_IDX) begin
                            state_reg <= DRAIN;
                        end else begin
                            j_reg <= j_reg + IDX_W'(1);
                        end
                    end else begin
                        ch_reg <= ch_reg + 2'd1;
                    end
                end
                DRAIN: begin
                end
                EMIT: begin
                    if (out_free) begin
                        m_valid_reg        <= 1'b1;
                        m_entry_index_reg  <= i_reg;
                        m_mapped_index_reg <= best_j_reg;
                        m_mapped_color_reg <= pfn_color(pal_reg, best_j_reg);
                        m_last_reg         <= (i_reg == LAST_IDX);
                        if (i_reg == LAST_IDX) begin
                            state_reg <= IDLE;
                        end else begin
                            i_reg     <= i_reg + IDX_W'(1);
                            state_reg <= SCALE;
                        end
                    end else if (m_valid_reg && m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                end
                default: state_reg <= IDLE;
            endcase

            // consume the registered product
            if (tag_out.vld) begin
                if (!tag_out.is_dist) begin
                    unique case (tag_out.ch)
                        CH_R:    sc_r_reg <= scaled;
                        CH_G:    sc_g_reg <= scaled;
                        default: sc_b_reg <= scaled;
                    endcase
                end else if (tag_out.ch == CH_B) begin
                    acc_reg <= '0;
                    if ((tag_out.j == '0) || (acc_sum < best_reg)) begin
                        best_reg   <= acc_sum;
                        best_j_reg <= tag_out.j;
                    end
                    if (tag_out.last_j) begin
                        state_reg <= EMIT;
                    end
                end else begin
                    acc_reg <= acc_sum;
                end
            end
        end
    end

    assign s_ready        = (state_reg == IDLE);
    assign m_valid        = m_valid_reg;
    assign m_entry_index  = m_entry_index_reg;
    assign m_mapped_index = m_mapped_index_reg;
    assign m_mapped_color = m_mapped_color_reg;
    assign m_last         = m_last_reg;

endmodule

`default_nettype wire

[rtl/pfn_mul.sv]
// ----------------------------------------------------------------------------
// pfn_mul
// Shared 14x14 multiplier with registered product and tag.
// ----------------------------------------------------------------------------
`default_nettype none

module pfn_mul
    import pfn_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [OP_W-1:0]   op_a,
    input  wire logic [OP_W-1:0]   op_b,
    input  wire pfn_tag_t          tag_in,
    output logic      [PROD_W-1:0] prod_reg,
    output pfn_tag_t               tag_reg
);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else begin
            tag_reg <= tag_in;
        end
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

endmodule

`default_nettype wire

[rtl/pfn_checker.sv]
// ----------------------------------------------------------------------------
// pfn_checker
// Port-level checks of the palette fade nearest color block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pfn_checker
    import pfn_pkg::*;
#(
    parameter int PALETTE_SIZE = PALETTE_SIZE_DEF
) (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [IDX_W-1:0]    m_entry_index,
    input wire logic                m_last
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_SIZE - 1);

    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_entry_index))
    `ASSERT_IMPLY(a_last_entry, aclk, aresetn, m_valid && m_last, m_entry_index == LAST_IDX)
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `ASSERT_IMPLY(a_busy_mid_run, aclk, aresetn, m_valid && !m_last, !s_ready)

endmodule

bind palette_fade_nearest_color pfn_checker #(
    .PALETTE_SIZE (PALETTE_SIZE)
) u_pfn_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_entry_index  (m_entry_index),
    .m_last         (m_last)
);

`default_nettype wire
